// File: src/imhpq_pkg.sv
package imhpq_pkg;

   localparam int KEY_COUNT  = 1024;
   localparam int KEY_BITS   = 10;
   localparam int CNT_BITS   = 11;
   localparam int PRIO_BITS  = 32;
   localparam int STAMP_BITS = 32;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_POP    = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_EMPTY  = 2'd1;
   localparam logic [1:0] STAT_ABSENT = 2'd2;

   typedef struct packed {
      logic [KEY_BITS-1:0]          key;
      logic signed [PRIO_BITS-1:0]  prio;
      logic [STAMP_BITS-1:0]        stamp;
   } entry_type;

   // smaller priority first, then earlier stamp
   function automatic logic comes_before(entry_type a, entry_type b);
      logic result;
      if (a.prio != b.prio) begin
         result = a.prio < b.prio;
      end else begin
         result = a.stamp < b.stamp;
      end
      return result;
   endfunction

endpackage

// File: src/indexed_min_heap_priority_queue.sv
// Channel  Direction  Ports                                           Transfer
// req      in         req_command, req_key, req_priority_req          req_valid & req_ready
// rsp      out        rsp_status, rsp_popped_key, rsp_popped_priority,
//                     rsp_min_key, rsp_min_valid, rsp_count            rsp_valid & rsp_ready
//
// One command at a time. A command looks up the key's slot first, and a remove or pop that moves
// the last entry then reads that entry; the entry sifts up level by level, then down, each level
// read through the single read port of the heap memory, and a child check, write-back and top
// read close the command. Clear goes straight to the final state. The result is valid the cycle
// after the final state. After reset a pass over all 1024 keys initializes the position memory
// before the first command; a waiting result holds the block in its final state until rsp_ready.
module indexed_min_heap_priority_queue (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [1:0]                               req_command,
   input  logic [imhpq_pkg::KEY_BITS-1:0]           req_key,
   input  logic signed [imhpq_pkg::PRIO_BITS-1:0]   req_priority_req,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [1:0]                               rsp_status,
   output logic [imhpq_pkg::KEY_BITS-1:0]           rsp_popped_key,
   output logic signed [imhpq_pkg::PRIO_BITS-1:0]   rsp_popped_priority,
   output logic [imhpq_pkg::KEY_BITS-1:0]           rsp_min_key,
   output logic                                     rsp_min_valid,
   output logic [imhpq_pkg::CNT_BITS-1:0]           rsp_count
);

   localparam int KB = imhpq_pkg::KEY_BITS;
   localparam int CB = imhpq_pkg::CNT_BITS;

   typedef enum logic [15:0] {
      ST_INIT    = 16'h0001,
      ST_IDLE    = 16'h0002,
      ST_LK_POS  = 16'h0004,
      ST_LK_HEAP = 16'h0008,
      ST_LK_DEC  = 16'h0010,
      ST_LAST_RD = 16'h0020,
      ST_LAST_WT = 16'h0040,
      ST_UP_RD   = 16'h0080,
      ST_UP_CMP  = 16'h0100,
      ST_DN_RDL  = 16'h0200,
      ST_DN_RDR  = 16'h0400,
      ST_DN_CMP  = 16'h0800,
      ST_PLACE   = 16'h1000,
      ST_MIN_RD  = 16'h2000,
      ST_MIN_WT  = 16'h4000,
      ST_DONE    = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]                              cmd_ff, cmd_in;
   logic [KB-1:0]                           key_ff, key_in;
   logic signed [imhpq_pkg::PRIO_BITS-1:0]  prio_ff, prio_in;
   logic [KB-1:0]                           idx_ff, idx_in;
   logic [CB-1:0]                           count_ff, count_in;
   logic [imhpq_pkg::STAMP_BITS-1:0]        stamp_ff, stamp_in;
   logic [KB-1:0]                           init_ff, init_in;
   imhpq_pkg::entry_type                    x_ff, x_in;
   imhpq_pkg::entry_type                    child_ff, child_in;
   logic                                    r_ok_ff, r_ok_in;
   logic [1:0]                              status_ff, status_in;
   logic [KB-1:0]                           pkey_ff, pkey_in;
   logic signed [imhpq_pkg::PRIO_BITS-1:0]  pprio_ff, pprio_in;
   logic [KB-1:0]                           mkey_ff, mkey_in;

   logic                                    rsp_valid_ff;
   logic [1:0]                              rsp_status_ff;
   logic [KB-1:0]                           rsp_pkey_ff;
   logic signed [imhpq_pkg::PRIO_BITS-1:0]  rsp_pprio_ff;
   logic [KB-1:0]                           rsp_mkey_ff;
   logic                                    rsp_mvalid_ff;
   logic [CB-1:0]                           rsp_count_ff;

   // heap memory port
   logic [KB-1:0]         heap_ra;
   imhpq_pkg::entry_type  heap_rd;
   logic                  heap_we;
   logic [KB-1:0]         heap_wa;
   imhpq_pkg::entry_type  heap_wd;

   // position memory
   logic [KB-1:0]  pos_mem [imhpq_pkg::KEY_COUNT];
   logic [KB-1:0]  pos_rd_ff;
   logic           pos_we;
   logic [KB-1:0]  pos_wa;
   logic [KB-1:0]  pos_wd;

   logic [KB-1:0]  idx_dec;
   logic [KB-1:0]  parent;
   logic [CB:0]    left_w;
   logic [CB:0]    right_w;
   logic           hit;
   logic           pick_right;
   imhpq_pkg::entry_type pick;
   logic [KB-1:0]  pick_idx;
   logic           take_rsp;

   imhpq_heap_ram u_heap (
      .clock   (clock),
      .rd_addr (heap_ra),
      .rd_data (heap_rd),
      .wr_en   (heap_we),
      .wr_addr (heap_wa),
      .wr_data (heap_wd)
   );

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_wa] <= pos_wd;
      end
      pos_rd_ff <= pos_mem[key_ff];
   end

   assign idx_dec  = idx_ff - 1'b1;
   assign parent   = {1'b0, idx_dec[KB-1:1]};
   assign left_w   = {1'b0, idx_ff, 1'b1};
   assign right_w  = left_w + 1'b1;
   // stale position entries are verified against the heap slot
   assign hit = (cmd_ff == imhpq_pkg::CMD_POP) ? (count_ff != '0) :
                (({1'b0, idx_ff} < count_ff) && (heap_rd.key == key_ff));
   assign pick_right = r_ok_ff && imhpq_pkg::comes_before(heap_rd, child_ff);
   assign pick       = pick_right ? heap_rd : child_ff;
   assign pick_idx   = pick_right ? right_w[KB-1:0] : left_w[KB-1:0];
   assign take_rsp   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      heap_ra = '0;
      heap_we = 1'b0;
      heap_wa = idx_ff;
      heap_wd = x_ff;
      pos_we  = 1'b0;
      pos_wa  = x_ff.key;
      pos_wd  = idx_ff;
      case (state_ff)
         ST_INIT: begin
            pos_we = 1'b1;
            pos_wa = init_ff;
            pos_wd = '0;
         end
         ST_LK_HEAP: begin
            heap_ra = (cmd_ff == imhpq_pkg::CMD_POP) ? '0 : pos_rd_ff;
         end
         ST_LAST_RD: begin
            heap_ra = count_ff[KB-1:0];
         end
         ST_UP_RD: begin
            heap_ra = parent;
         end
         ST_UP_CMP: begin
            if (imhpq_pkg::comes_before(x_ff, heap_rd)) begin
               heap_we = 1'b1;
               heap_wd = heap_rd;
               pos_we  = 1'b1;
               pos_wa  = heap_rd.key;
            end
         end
         ST_DN_RDL: begin
            heap_ra = left_w[KB-1:0];
         end
         ST_DN_RDR: begin
            heap_ra = right_w[KB-1:0];
         end
         ST_DN_CMP: begin
            if (imhpq_pkg::comes_before(pick, x_ff)) begin
               heap_we = 1'b1;
               heap_wd = pick;
               pos_we  = 1'b1;
               pos_wa  = pick.key;
            end
         end
         ST_PLACE: begin
            heap_we = 1'b1;
            pos_we  = 1'b1;
         end
         default: begin
            heap_ra = '0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      key_in    = key_ff;
      prio_in   = prio_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      stamp_in  = stamp_ff;
      init_in   = init_ff;
      x_in      = x_ff;
      child_in  = child_ff;
      r_ok_in   = r_ok_ff;
      status_in = status_ff;
      pkey_in   = pkey_ff;
      pprio_in  = pprio_ff;
      mkey_in   = mkey_ff;
      case (state_ff)
         ST_INIT: begin
            init_in = init_ff + 1'b1;
            if (init_ff == {KB{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_command;
               key_in    = req_key;
               prio_in   = req_priority_req;
               status_in = imhpq_pkg::STAT_OK;
               pkey_in   = '0;
               pprio_in  = '0;
               if (req_command == imhpq_pkg::CMD_CLEAR) begin
                  count_in = '0;
                  stamp_in = '0;
                  mkey_in  = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_LK_POS;
               end
            end
         end
         ST_LK_POS: begin
            state_in = ST_LK_HEAP;
         end
         ST_LK_HEAP: begin
            idx_in   = (cmd_ff == imhpq_pkg::CMD_POP) ? '0 : pos_rd_ff;
            state_in = ST_LK_DEC;
         end
         ST_LK_DEC: begin
            state_in = ST_MIN_RD;
            if (cmd_ff == imhpq_pkg::CMD_INSERT) begin
               if (hit) begin
                  x_in     = '{key: key_ff, prio: prio_ff, stamp: heap_rd.stamp};
                  state_in = (idx_ff == '0) ? ST_DN_RDL : ST_UP_RD;
               end else if (count_ff != CB'(imhpq_pkg::KEY_COUNT)) begin
                  x_in     = '{key: key_ff, prio: prio_ff, stamp: stamp_ff};
                  idx_in   = count_ff[KB-1:0];
                  count_in = count_ff + 1'b1;
                  stamp_in = stamp_ff + 1'b1;
                  state_in = (count_ff == '0) ? ST_DN_RDL : ST_UP_RD;
               end
            end else if (!hit) begin
               status_in = (cmd_ff == imhpq_pkg::CMD_POP) ? imhpq_pkg::STAT_EMPTY :
                                                            imhpq_pkg::STAT_ABSENT;
            end else begin
               pkey_in  = heap_rd.key;
               pprio_in = heap_rd.prio;
               count_in = count_ff - 1'b1;
               if ({1'b0, idx_ff} != count_ff - 1'b1) begin
                  state_in = ST_LAST_RD;
               end
            end
         end
         ST_LAST_RD: begin
            state_in = ST_LAST_WT;
         end
         ST_LAST_WT: begin
            x_in     = heap_rd;
            state_in = (idx_ff == '0) ? ST_DN_RDL : ST_UP_RD;
         end
         ST_UP_RD: begin
            state_in = ST_UP_CMP;
         end
         ST_UP_CMP: begin
            if (imhpq_pkg::comes_before(x_ff, heap_rd)) begin
               idx_in   = parent;
               state_in = (parent == '0) ? ST_DN_RDL : ST_UP_RD;
            end else begin
               state_in = ST_DN_RDL;
            end
         end
         ST_DN_RDL: begin
            state_in = (left_w >= {1'b0, count_ff}) ? ST_PLACE : ST_DN_RDR;
         end
         ST_DN_RDR: begin
            child_in = heap_rd;
            r_ok_in  = right_w < {1'b0, count_ff};
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            if (imhpq_pkg::comes_before(pick, x_ff)) begin
               idx_in   = pick_idx;
               state_in = ST_DN_RDL;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            state_in = ST_MIN_RD;
         end
         ST_MIN_RD: begin
            state_in = ST_MIN_WT;
         end
         ST_MIN_WT: begin
            mkey_in  = (count_ff == '0) ? '0 : heap_rd.key;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (take_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_ff      <= '0;
         count_ff     <= '0;
         stamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         count_ff <= count_in;
         stamp_ff <= stamp_in;
         if (state_ff == ST_DONE && take_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      prio_ff   <= prio_in;
      idx_ff    <= idx_in;
      x_ff      <= x_in;
      child_ff  <= child_in;
      r_ok_ff   <= r_ok_in;
      status_ff <= status_in;
      pkey_ff   <= pkey_in;
      pprio_ff  <= pprio_in;
      mkey_ff   <= mkey_in;
      if (state_ff == ST_DONE && take_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_pkey_ff   <= pkey_ff;
         rsp_pprio_ff  <= pprio_ff;
         rsp_mkey_ff   <= mkey_ff;
         rsp_mvalid_ff <= count_ff != '0;
         rsp_count_ff  <= count_ff;
      end
   end

   assign req_ready           = state_ff == ST_IDLE;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_popped_key      = rsp_pkey_ff;
   assign rsp_popped_priority = rsp_pprio_ff;
   assign rsp_min_key         = rsp_mkey_ff;
   assign rsp_min_valid       = rsp_mvalid_ff;
   assign rsp_count           = rsp_count_ff;

endmodule

// File: src/imhpq_heap_ram.sv
module imhpq_heap_ram (
   input  logic                              clock,
   input  logic [imhpq_pkg::KEY_BITS-1:0]    rd_addr,
   output imhpq_pkg::entry_type              rd_data,
   input  logic                              wr_en,
   input  logic [imhpq_pkg::KEY_BITS-1:0]    wr_addr,
   input  imhpq_pkg::entry_type              wr_data
);

   imhpq_pkg::entry_type mem [imhpq_pkg::KEY_COUNT];
   imhpq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: dv/indexed_min_heap_priority_queue_tb.sv
module indexed_min_heap_priority_queue_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [1:0]                             status;
      logic [imhpq_pkg::KEY_BITS-1:0]         popped_key;
      logic signed [imhpq_pkg::PRIO_BITS-1:0] popped_priority;
      logic [imhpq_pkg::KEY_BITS-1:0]         min_key;
      logic                                   min_valid;
      logic [imhpq_pkg::CNT_BITS-1:0]         count;
   } outcome_type;

   typedef struct packed {
      logic [1:0]                             command;
      logic [imhpq_pkg::KEY_BITS-1:0]         key;
      logic signed [imhpq_pkg::PRIO_BITS-1:0] priority_req;
      logic                                   typed;
      outcome_type                            outcome;
   } step_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_command = imhpq_pkg::CMD_CLEAR;
   logic [imhpq_pkg::KEY_BITS-1:0] req_key = '0;
   logic signed [imhpq_pkg::PRIO_BITS-1:0] req_priority_req = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [imhpq_pkg::KEY_BITS-1:0] rsp_popped_key;
   logic signed [imhpq_pkg::PRIO_BITS-1:0] rsp_popped_priority;
   logic [imhpq_pkg::KEY_BITS-1:0] rsp_min_key;
   logic rsp_min_valid;
   logic [imhpq_pkg::CNT_BITS-1:0] rsp_count;

   indexed_min_heap_priority_queue uut (.*);

   always #1 clock = ~clock;

   // shadow heap
   logic [imhpq_pkg::KEY_BITS-1:0]         slot_key [imhpq_pkg::KEY_COUNT];
   logic signed [imhpq_pkg::PRIO_BITS-1:0] slot_prio [imhpq_pkg::KEY_COUNT];
   logic [imhpq_pkg::STAMP_BITS-1:0]       slot_stamp [imhpq_pkg::KEY_COUNT];
   int                                     key_slot [imhpq_pkg::KEY_COUNT];
   bit                                     key_held [imhpq_pkg::KEY_COUNT];
   int                                     held_count;
   logic [imhpq_pkg::STAMP_BITS-1:0]       next_stamp;

   outcome_type  pending_outcomes[$];
   step_row_type directed_rows[$];
   int  failures = 0;
   int  cycles = 0;
   bit  quiet = 1'b0;
   bit  hold_request = 1'b0;

   function automatic bit ahead(int a, int b);
      if (slot_prio[a] != slot_prio[b]) return slot_prio[a] < slot_prio[b];
      return slot_stamp[a] < slot_stamp[b];
   endfunction

   function automatic void swap_slots(int a, int b);
      logic [imhpq_pkg::KEY_BITS-1:0] k;
      logic signed [imhpq_pkg::PRIO_BITS-1:0] p;
      logic [imhpq_pkg::STAMP_BITS-1:0] s;
      k = slot_key[a];   slot_key[a] = slot_key[b];     slot_key[b] = k;
      p = slot_prio[a];  slot_prio[a] = slot_prio[b];   slot_prio[b] = p;
      s = slot_stamp[a]; slot_stamp[a] = slot_stamp[b]; slot_stamp[b] = s;
      key_slot[slot_key[a]] = a;
      key_slot[slot_key[b]] = b;
   endfunction

   function automatic void sift_up(int i);
      int p;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!ahead(i, p)) break;
         swap_slots(i, p);
         i = p;
      end
   endfunction

   function automatic void sift_down(int i);
      int l, c;
      forever begin
         l = 2 * i + 1;
         c = l;
         if (l >= held_count) break;
         if (l + 1 < held_count && ahead(l + 1, l)) c = l + 1;
         if (!ahead(c, i)) break;
         swap_slots(c, i);
         i = c;
      end
   endfunction

   function automatic void take_out(int k);
      int i, last;
      i = key_slot[k];
      last = held_count - 1;
      if (i != last) swap_slots(i, last);
      key_held[k] = 1'b0;
      held_count = last;
      if (i < held_count) begin
         sift_up(i);
         sift_down(key_slot[slot_key[i]]);
      end
   endfunction

   function automatic outcome_type apply_command(logic [1:0] command,
                                                 logic [imhpq_pkg::KEY_BITS-1:0] key,
                                                 logic signed [imhpq_pkg::PRIO_BITS-1:0] prio);
      outcome_type o;
      int i;
      o = '0;
      o.status = imhpq_pkg::STAT_OK;
      case (command)
         imhpq_pkg::CMD_INSERT: begin
            if (key_held[key]) begin
               i = key_slot[key];
               slot_prio[i] = prio;
               sift_up(i);
               sift_down(key_slot[key]);
            end else if (held_count < imhpq_pkg::KEY_COUNT) begin
               i = held_count;
               slot_key[i] = key;
               slot_prio[i] = prio;
               slot_stamp[i] = next_stamp;
               next_stamp = next_stamp + 1'b1;
               key_slot[key] = i;
               key_held[key] = 1'b1;
               held_count++;
               sift_up(i);
            end
         end
         imhpq_pkg::CMD_REMOVE: begin
            if (!key_held[key]) begin
               o.status = imhpq_pkg::STAT_ABSENT;
            end else begin
               o.popped_key = key;
               o.popped_priority = slot_prio[key_slot[key]];
               take_out(key);
            end
         end
         imhpq_pkg::CMD_POP: begin
            if (held_count == 0) begin
               o.status = imhpq_pkg::STAT_EMPTY;
            end else begin
               o.popped_key = slot_key[0];
               o.popped_priority = slot_prio[0];
               take_out(slot_key[0]);
            end
         end
         default: begin
            for (int k = 0; k < imhpq_pkg::KEY_COUNT; k++) key_held[k] = 1'b0;
            held_count = 0;
            next_stamp = '0;
         end
      endcase
      o.min_valid = held_count != 0;
      o.min_key = held_count != 0 ? slot_key[0] : '0;
      o.count = imhpq_pkg::CNT_BITS'(held_count);
      return o;
   endfunction

   task automatic add_row(logic [1:0] c, logic [imhpq_pkg::KEY_BITS-1:0] k,
                          logic signed [31:0] p);
      directed_rows.push_back('{c, k, p, 1'b0, '0});
   endtask

   task automatic add_typed(logic [1:0] c, logic [imhpq_pkg::KEY_BITS-1:0] k,
                            logic signed [31:0] p, outcome_type o);
      directed_rows.push_back('{c, k, p, 1'b1, o});
   endtask

   // drive one command and hold it until the transfer
   task automatic send_command(logic [1:0] c, logic [imhpq_pkg::KEY_BITS-1:0] k,
                               logic signed [31:0] p, bit typed, outcome_type typed_outcome);
      outcome_type o;
      int gap;
      gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= c;
      req_key <= k;
      req_priority_req <= p;
      do @(posedge clock); while (!req_ready);
      o = apply_command(c, k, p);
      pending_outcomes.push_back(typed ? typed_outcome : o);
   endtask

   task automatic send_random(int key_span, int insert_weight);
      logic [1:0] c;
      logic signed [31:0] p;
      logic [imhpq_pkg::KEY_BITS-1:0] k;
      int r;
      r = $urandom_range(0, 99);
      if (r < insert_weight) c = imhpq_pkg::CMD_INSERT;
      else if (r < insert_weight + (100 - insert_weight) / 2) c = imhpq_pkg::CMD_POP;
      else if (r < 99) c = imhpq_pkg::CMD_REMOVE;
      else c = imhpq_pkg::CMD_CLEAR;
      // narrow priorities force ties on the stamp
      p = $urandom_range(0, 2) == 0 ? $signed($urandom_range(0, 8)) - 4 : $urandom;
      k = imhpq_pkg::KEY_BITS'($urandom_range(0, key_span));
      send_command(c, k, p, 1'b0, '0);
   endtask

   task automatic report(string field, longint e, longint g);
      $display("%0t: %s expected %0h got %0h", $time, field, e, g);
      failures++;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("** indexed_min_heap_priority_queue: FAILED **");
         $finish;
      end
   end

   // result side: check transfers, stall at random, honor the long hold
   initial begin
      outcome_type e;
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               $display("%0t: unexpected result, status %0d", $time, rsp_status);
               failures++;
            end else begin
               e = pending_outcomes.pop_front();
               if (rsp_status != e.status) report("status", e.status, rsp_status);
               if (rsp_popped_key != e.popped_key)
                  report("popped_key", e.popped_key, rsp_popped_key);
               if (rsp_popped_priority != e.popped_priority)
                  report("popped_priority", e.popped_priority, rsp_popped_priority);
               if (rsp_min_key != e.min_key) report("min_key", e.min_key, rsp_min_key);
               if (rsp_min_valid != e.min_valid)
                  report("min_valid", e.min_valid, rsp_min_valid);
               if (rsp_count != e.count) report("count", e.count, rsp_count);
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = 400;
         end else if (stall_left == 0 && !quiet && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 9);
         end
         if (stall_left > 0) stall_left--;
         rsp_ready <= (stall_left == 0) && !reset;
      end
   end

   initial begin
      held_count = 0;
      next_stamp = '0;
      for (int k = 0; k < imhpq_pkg::KEY_COUNT; k++) key_held[k] = 1'b0;

      add_typed(imhpq_pkg::CMD_POP, 10'd0, 32'sd0,
                '{imhpq_pkg::STAT_EMPTY, 10'd0, 32'sd0, 10'd0, 1'b0, 11'd0});
      add_typed(imhpq_pkg::CMD_REMOVE, 10'd5, 32'sd0,
                '{imhpq_pkg::STAT_ABSENT, 10'd0, 32'sd0, 10'd0, 1'b0, 11'd0});
      add_typed(imhpq_pkg::CMD_INSERT, 10'd0, 32'sh7FFFFFFF,
                '{imhpq_pkg::STAT_OK, 10'd0, 32'sd0, 10'd0, 1'b1, 11'd1});
      add_typed(imhpq_pkg::CMD_INSERT, 10'd1023, 32'sh80000000,
                '{imhpq_pkg::STAT_OK, 10'd0, 32'sd0, 10'd1023, 1'b1, 11'd2});
      // equal priority, later stamp stays below
      add_typed(imhpq_pkg::CMD_INSERT, 10'd512, 32'sh80000000,
                '{imhpq_pkg::STAT_OK, 10'd0, 32'sd0, 10'd1023, 1'b1, 11'd3});
      // update keeps the earliest stamp, so key 0 wins the tie
      add_typed(imhpq_pkg::CMD_INSERT, 10'd0, 32'sh80000000,
                '{imhpq_pkg::STAT_OK, 10'd0, 32'sd0, 10'd0, 1'b1, 11'd3});
      add_typed(imhpq_pkg::CMD_INSERT, 10'd0, 32'sh7FFFFFFF,
                '{imhpq_pkg::STAT_OK, 10'd0, 32'sd0, 10'd1023, 1'b1, 11'd3});
      add_typed(imhpq_pkg::CMD_REMOVE, 10'd512, 32'sd0,
                '{imhpq_pkg::STAT_OK, 10'd512, 32'sh80000000, 10'd1023, 1'b1, 11'd2});
      add_typed(imhpq_pkg::CMD_REMOVE, 10'd512, 32'sd0,
                '{imhpq_pkg::STAT_ABSENT, 10'd0, 32'sd0, 10'd1023, 1'b1, 11'd2});
      add_typed(imhpq_pkg::CMD_POP, 10'd0, 32'sd0,
                '{imhpq_pkg::STAT_OK, 10'd1023, 32'sh80000000, 10'd0, 1'b1, 11'd1});
      add_row(imhpq_pkg::CMD_INSERT, 10'd3, -32'sd1);
      add_row(imhpq_pkg::CMD_INSERT, 10'd7, 32'sd1);
      add_row(imhpq_pkg::CMD_INSERT, 10'd9, -32'sd1);
      add_row(imhpq_pkg::CMD_INSERT, 10'd7, -32'sd65536);
      add_row(imhpq_pkg::CMD_REMOVE, 10'd3, 32'sd0);
      add_row(imhpq_pkg::CMD_POP, 10'd0, 32'sd0);
      add_typed(imhpq_pkg::CMD_CLEAR, 10'd0, 32'sd0,
                '{imhpq_pkg::STAT_OK, 10'd0, 32'sd0, 10'd0, 1'b0, 11'd0});
      add_typed(imhpq_pkg::CMD_POP, 10'd0, 32'sd0,
                '{imhpq_pkg::STAT_EMPTY, 10'd0, 32'sd0, 10'd0, 1'b0, 11'd0});
      add_row(imhpq_pkg::CMD_INSERT, 10'd1, 32'sd5);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_command(directed_rows[i].command, directed_rows[i].key,
                      directed_rows[i].priority_req, directed_rows[i].typed,
                      directed_rows[i].outcome);

      repeat (130) send_random(15, 55);
      repeat (130) send_random(1023, 80);

      // stall the result side long enough for the input to back up
      hold_request = 1'b1;
      repeat (40) send_random(31, 60);

      // let every expected result arrive before going on
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);

      repeat (60) send_random(1023, 40);
      quiet = 1'b1;
      repeat (90) send_random(63, 55);
      req_valid <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("** indexed_min_heap_priority_queue: PASSED **");
      end else begin
         $display("** indexed_min_heap_priority_queue: FAILED **");
      end
      $finish;
   end

endmodule
